// ===== hdl/vcg_pkg.sv =====
package vcg_pkg;

  localparam int LIMB_W  = 32;
  localparam int ACC_W   = 160;
  localparam int S0_W    = 128;
  localparam int S1_W    = 96;
  localparam int INNER_W = 36;
  localparam int DT_W    = 20;
  localparam int STEP_W  = 5;
  localparam logic [STEP_W-1:0] LAST_STEP = 5'd20;

  localparam logic signed [31:0] TICK_US = 32'sd16000;
  localparam logic signed [31:0] MAX_US  = 32'sd1000000;
  localparam logic [31:0]        SCALE_K = 32'd256000000;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_HH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZOOM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REJ  = 2'd2;
  localparam logic [15:0] CFG_HH_RST   = 16'd1024;
  localparam logic [15:0] CFG_ZOOM_RST = 16'd512;
  localparam logic [7:0]  CFG_REJ_RST  = 8'd3;

  localparam logic [1:0] REASON_OK      = 2'd0;
  localparam logic [1:0] REASON_INVALID = 2'd1;
  localparam logic [1:0] REASON_HELD    = 2'd2;

  typedef enum logic [3:0] {
    OP_AX, OP_AY, OP_LO, OP_HI, OP_H, OP_Z, OP_DT, OP_K, OP_S0, OP_S1, OP_INNER
  } opsel_e;

  typedef enum logic [1:0] {DST_NONE, DST_S0, DST_S1} dst_e;

  typedef enum logic [1:0] {RES_INVALID, RES_ADOPT, RES_HOLD} res_e;

  typedef struct packed {
    logic       en;
    logic       clr;
    opsel_e     a_sel;
    logic [1:0] a_limb;
    opsel_e     b_sel;
    logic [1:0] b_limb;
    logic [2:0] shift;
    logic       dbl;
    dst_e       dst;
    logic       ld_inner;
    logic       cmp_fast;
  } mac_cmd_t;

  typedef struct packed {
    logic     load;
    mac_cmd_t mac;
    logic     commit;
    res_e     kind;
  } dp_cmd_t;

  typedef struct packed {
    logic in_need_cmp;
    logic valid;
    logic need_cmp;
    logic exceed;
    logic below_limit;
  } dp_status_t;

  localparam mac_cmd_t MAC_NOP = '{
    en: 1'b0, clr: 1'b0, a_sel: OP_AX, a_limb: 2'd0, b_sel: OP_AX, b_limb: 2'd0,
    shift: 3'd0, dbl: 1'b0, dst: DST_NONE, ld_inner: 1'b0, cmp_fast: 1'b0
  };

  // zoom test first (steps 0-4), then moved^2 * K^2 into s0, then (lo*H*dt)^2 in acc
  function automatic mac_cmd_t step_cmd(input logic [STEP_W-1:0] idx);
    mac_cmd_t c;
    c = MAC_NOP;
    c.en = 1'b1;
    case (idx)
      5'd0: begin
        c.clr = 1'b1; c.a_sel = OP_Z; c.b_sel = OP_DT;
      end
      5'd1: begin
        c.ld_inner = 1'b1; c.clr = 1'b1; c.a_sel = OP_HI; c.b_sel = OP_K; c.dst = DST_S0;
      end
      5'd2: begin
        c.clr = 1'b1; c.a_sel = OP_LO; c.b_sel = OP_INNER; c.b_limb = 2'd0;
      end
      5'd3: begin
        c.a_sel = OP_LO; c.b_sel = OP_INNER; c.b_limb = 2'd1; c.shift = 3'd1;
      end
      5'd4: begin
        c.cmp_fast = 1'b1; c.clr = 1'b1; c.a_sel = OP_AX; c.b_sel = OP_AX;
      end
      5'd5: begin
        c.a_sel = OP_AY; c.b_sel = OP_AY; c.dst = DST_S0;
      end
      5'd6, 5'd9: begin
        c.clr = 1'b1; c.a_sel = OP_S0; c.a_limb = 2'd0; c.b_sel = OP_K;
      end
      5'd7, 5'd10: begin
        c.a_sel = OP_S0; c.a_limb = 2'd1; c.b_sel = OP_K; c.shift = 3'd1;
      end
      5'd8, 5'd11: begin
        c.a_sel = OP_S0; c.a_limb = 2'd2; c.b_sel = OP_K; c.shift = 3'd2; c.dst = DST_S0;
      end
      5'd12: begin
        c.clr = 1'b1; c.a_sel = OP_LO; c.b_sel = OP_H; c.dst = DST_S1;
      end
      5'd13: begin
        c.clr = 1'b1; c.a_sel = OP_S1; c.a_limb = 2'd0; c.b_sel = OP_DT;
      end
      5'd14: begin
        c.a_sel = OP_S1; c.a_limb = 2'd1; c.b_sel = OP_DT; c.shift = 3'd1; c.dst = DST_S1;
      end
      5'd15: begin
        c.clr = 1'b1; c.a_sel = OP_S1; c.a_limb = 2'd0; c.b_sel = OP_S1; c.b_limb = 2'd0;
      end
      5'd16: begin
        c.a_sel = OP_S1; c.a_limb = 2'd0; c.b_sel = OP_S1; c.b_limb = 2'd1;
        c.shift = 3'd1; c.dbl = 1'b1;
      end
      5'd17: begin
        c.a_sel = OP_S1; c.a_limb = 2'd1; c.b_sel = OP_S1; c.b_limb = 2'd1; c.shift = 3'd2;
      end
      5'd18: begin
        c.a_sel = OP_S1; c.a_limb = 2'd0; c.b_sel = OP_S1; c.b_limb = 2'd2;
        c.shift = 3'd2; c.dbl = 1'b1;
      end
      5'd19: begin
        c.a_sel = OP_S1; c.a_limb = 2'd1; c.b_sel = OP_S1; c.b_limb = 2'd2;
        c.shift = 3'd3; c.dbl = 1'b1;
      end
      5'd20: begin
        c.a_sel = OP_S1; c.a_limb = 2'd2; c.b_sel = OP_S1; c.b_limb = 2'd2; c.shift = 3'd4;
      end
      default: c = MAC_NOP;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/vcg_datapath.sv =====
module vcg_datapath
  import vcg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_tuser_i,
  input  logic [127:0]          s_tdata_i,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  output logic [2:0]            m_tuser_o,
  output logic [7:0]            m_tdata_o
);

  logic [15:0] cfg_hh_q, cfg_zoom_q;
  logic [7:0]  cfg_rej_q;

  logic               have_ref_q;
  logic signed [31:0] ref_x_q, ref_y_q;
  logic [30:0]        ref_hh_q;
  logic [7:0]         rej_q, rej_d;

  logic signed [31:0] cx_q, cy_q;
  logic [30:0]        hh_q, lo_q, hi_q;
  logic [31:0]        ax_q, ay_q;
  logic [DT_W-1:0]    dt_q;
  logic               valid_q, need_cmp_q, too_fast_q;

  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [S0_W-1:0]    s0_q;
  logic [S1_W-1:0]    s1_q;
  logic [INNER_W-1:0] inner_q, inner_d;

  logic               out_acc_q;
  logic [1:0]         out_reason_q;
  logic [7:0]         out_run_q;

  logic signed [31:0] in_x, in_y, in_et;
  logic [30:0]        in_hh, lo_d, hi_d;
  logic signed [32:0] dx, dy;
  logic [31:0]        ax_d, ay_d;
  logic [DT_W-1:0]    dt_d;
  logic [127:0]       s1_ext;
  logic [63:0]        inner_ext;
  logic [31:0]        a_word, b_word;
  logic [63:0]        prod;
  logic [64:0]        prod_x;
  logic [ACC_W-1:0]   term;
  logic               too_far;

  assign in_x  = s_tdata_i[31:0];
  assign in_y  = s_tdata_i[63:32];
  assign in_hh = s_tdata_i[94:64];
  assign in_et = s_tdata_i[126:95];

  assign dx   = {in_x[31], in_x} - {ref_x_q[31], ref_x_q};
  assign dy   = {in_y[31], in_y} - {ref_y_q[31], ref_y_q};
  assign ax_d = dx[32] ? 32'(-dx) : dx[31:0];
  assign ay_d = dy[32] ? 32'(-dy) : dy[31:0];
  assign lo_d = (in_hh < ref_hh_q) ? in_hh : ref_hh_q;
  assign hi_d = (in_hh > ref_hh_q) ? in_hh : ref_hh_q;

  always_comb begin
    if (in_et <= TICK_US) begin
      dt_d = DT_W'(TICK_US);
    end else if (in_et > MAX_US) begin
      dt_d = DT_W'(MAX_US);
    end else begin
      dt_d = in_et[DT_W-1:0];
    end
  end

  assign s1_ext    = {{(128 - S1_W){1'b0}}, s1_q};
  assign inner_ext = {{(64 - INNER_W){1'b0}}, inner_q};

  always_comb begin
    case (cmd_i.mac.a_sel)
      OP_AX:    a_word = ax_q;
      OP_AY:    a_word = ay_q;
      OP_LO:    a_word = {1'b0, lo_q};
      OP_HI:    a_word = {1'b0, hi_q};
      OP_H:     a_word = {16'd0, cfg_hh_q};
      OP_Z:     a_word = {16'd0, cfg_zoom_q};
      OP_DT:    a_word = {{(32 - DT_W){1'b0}}, dt_q};
      OP_K:     a_word = SCALE_K;
      OP_S0:    a_word = s0_q[LIMB_W*cmd_i.mac.a_limb +: LIMB_W];
      OP_S1:    a_word = s1_ext[LIMB_W*cmd_i.mac.a_limb +: LIMB_W];
      OP_INNER: a_word = inner_ext[LIMB_W*cmd_i.mac.a_limb[0] +: LIMB_W];
      default:  a_word = '0;
    endcase
    case (cmd_i.mac.b_sel)
      OP_AX:    b_word = ax_q;
      OP_AY:    b_word = ay_q;
      OP_LO:    b_word = {1'b0, lo_q};
      OP_HI:    b_word = {1'b0, hi_q};
      OP_H:     b_word = {16'd0, cfg_hh_q};
      OP_Z:     b_word = {16'd0, cfg_zoom_q};
      OP_DT:    b_word = {{(32 - DT_W){1'b0}}, dt_q};
      OP_K:     b_word = SCALE_K;
      OP_S0:    b_word = s0_q[LIMB_W*cmd_i.mac.b_limb +: LIMB_W];
      OP_S1:    b_word = s1_ext[LIMB_W*cmd_i.mac.b_limb +: LIMB_W];
      OP_INNER: b_word = inner_ext[LIMB_W*cmd_i.mac.b_limb[0] +: LIMB_W];
      default:  b_word = '0;
    endcase
  end

  assign prod    = a_word * b_word;
  assign prod_x  = cmd_i.mac.dbl ? {prod, 1'b0} : {1'b0, prod};
  assign term    = ACC_W'(prod_x) << (LIMB_W * cmd_i.mac.shift);
  assign acc_d   = (cmd_i.mac.clr ? '0 : acc_q) + term;
  // K + Z*dt - 256*dt, never negative for dt up to one second
  assign inner_d = INNER_W'(SCALE_K) + acc_q[INNER_W-1:0] - INNER_W'({dt_q, 8'd0});
  assign too_far = {{(ACC_W - S0_W){1'b0}}, s0_q} > acc_q;
  assign rej_d   = (rej_q == 8'hFF) ? rej_q : rej_q + 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_hh_q   <= CFG_HH_RST;
      cfg_zoom_q <= CFG_ZOOM_RST;
      cfg_rej_q  <= CFG_REJ_RST;
      have_ref_q <= 1'b0;
      ref_x_q    <= '0;
      ref_y_q    <= '0;
      ref_hh_q   <= '0;
      rej_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HH:   cfg_hh_q   <= cfg_data_i;
          CFG_ZOOM: cfg_zoom_q <= cfg_data_i;
          CFG_REJ:  cfg_rej_q  <= cfg_data_i[7:0];
          default:  ;
        endcase
      end
      if (cmd_i.commit) begin
        case (cmd_i.kind)
          RES_INVALID: ;
          RES_HOLD:    rej_q <= rej_d;
          default: begin
            have_ref_q <= 1'b1;
            ref_x_q    <= cx_q;
            ref_y_q    <= cy_q;
            ref_hh_q   <= hh_q;
            rej_q      <= '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      valid_q    <= s_tuser_i;
      need_cmp_q <= s_tuser_i & have_ref_q & (in_hh != '0) & (ref_hh_q != '0);
      cx_q       <= in_x;
      cy_q       <= in_y;
      hh_q       <= in_hh;
      ax_q       <= ax_d;
      ay_q       <= ay_d;
      lo_q       <= lo_d;
      hi_q       <= hi_d;
      dt_q       <= dt_d;
    end
    if (cmd_i.mac.en) begin
      acc_q <= acc_d;
      case (cmd_i.mac.dst)
        DST_S0:  s0_q <= acc_d[S0_W-1:0];
        DST_S1:  s1_q <= acc_d[S1_W-1:0];
        default: ;
      endcase
    end
    if (cmd_i.mac.ld_inner) begin
      inner_q <= inner_d;
    end
    if (cmd_i.mac.cmp_fast) begin
      too_fast_q <= too_far;
    end
    if (cmd_i.commit) begin
      case (cmd_i.kind)
        RES_INVALID: begin
          out_acc_q    <= 1'b0;
          out_reason_q <= REASON_INVALID;
          out_run_q    <= rej_q;
        end
        RES_HOLD: begin
          out_acc_q    <= 1'b0;
          out_reason_q <= REASON_HELD;
          out_run_q    <= rej_d;
        end
        default: begin
          out_acc_q    <= 1'b1;
          out_reason_q <= REASON_OK;
          out_run_q    <= '0;
        end
      endcase
    end
  end

  assign status_o.in_need_cmp = s_tuser_i & have_ref_q & (in_hh != '0) & (ref_hh_q != '0);
  assign status_o.valid       = valid_q;
  assign status_o.need_cmp    = need_cmp_q;
  assign status_o.exceed      = too_far | too_fast_q;
  assign status_o.below_limit = rej_q < cfg_rej_q;

  assign m_tuser_o = {out_reason_q, out_acc_q};
  assign m_tdata_o = out_run_q;

endmodule

// ===== hdl/vcg_ctrl.sv =====
module vcg_ctrl
  import vcg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  input  logic       m_tready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       s_tready_o,
  output logic       m_tvalid_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '{load: 1'b0, mac: MAC_NOP, commit: 1'b0, kind: RES_ADOPT};
    s_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = status_i.in_need_cmp ? ST_CALC : ST_DONE;
        end
      end
      ST_CALC: begin
        cmd_o.mac = step_cmd(step_q);
        step_d    = step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_tready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
          if (!status_i.valid) begin
            cmd_o.kind = RES_INVALID;
          end else if (status_i.need_cmp && status_i.exceed && status_i.below_limit) begin
            cmd_o.kind = RES_HOLD;
          end else begin
            cmd_o.kind = RES_ADOPT;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_tvalid_o = out_valid_q;

endmodule

// ===== hdl/view_continuity_guard.sv =====
// Samples that need no continuity test (invalid, no reference pose or a zero half-height)
// go straight to the result; otherwise the tests take 21 steps on one shared 32x32
// multiply-accumulate. One sample is in work at a time; a waiting result does not block
// the next input, but that sample's result is held until the waiting one is taken.
// Reset (rst_ni low, asynchronous): no reference pose, reject count 0, configuration registers at defaults.
module view_continuity_guard
  import vcg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // centre_x[31:0], centre_y[63:32], half_height[94:64], elapsed_us[126:95]
  input  logic [127:0]          s_axis_tdata,
  // sample_valid[0]
  input  logic [0:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // reject_run[7:0]
  output logic [7:0]            m_axis_tdata,
  // accepted[0], reason[2:1]
  output logic [2:0]            m_axis_tuser
);

  dp_cmd_t    cmd;
  dp_status_t status;

  vcg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid)
  );

  vcg_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tuser_i  (s_axis_tuser[0]),
    .s_tdata_i  (s_axis_tdata),
    .cmd_i      (cmd),
    .status_o   (status),
    .m_tuser_o  (m_axis_tuser),
    .m_tdata_o  (m_axis_tdata)
  );

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result written over an untaken beat");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second beat accepted while a sample is in work");

  a_accept_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tuser[2:1] == REASON_OK && m_axis_tdata == 8'd0))
    else $error("accepted beat with reason or reject run set");

  a_commit_idle_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> (s_axis_tready && m_axis_tvalid))
    else $error("commit did not return to idle with a result");

endmodule

// ===== sim/tb_view_continuity_guard.sv =====
module tb_view_continuity_guard;
  import vcg_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 30;
  localparam int PHASE_ITEMS = 50;

  typedef struct {
    logic               valid;
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic [30:0]        half_height;
    logic signed [31:0] elapsed_us;
  } pose_t;

  typedef struct {
    logic       taken;
    logic [1:0] reason;
    logic [7:0] streak;
  } verdict_t;

  class pose_verdict_board;
    bit                 anchored = 1'b0;
    logic signed [31:0] anchor_x = '0;
    logic signed [31:0] anchor_y = '0;
    logic [30:0]        anchor_hh = '0;
    logic [7:0]         reject_count = '0;
    logic [15:0]        hh_limit = CFG_HH_RST;
    logic [15:0]        zoom_limit = CFG_ZOOM_RST;
    logic [7:0]         reject_limit = CFG_REJ_RST;
    verdict_t           expected_verdicts[$];
    int                 errors = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_HH:   hh_limit = value;
        CFG_ZOOM: zoom_limit = value;
        CFG_REJ:  reject_limit = value[7:0];
        default: ;
      endcase
    endfunction

    function void note_sample(pose_t p);
      logic signed [63:0] dt, dx, dy, zdelta, inner;
      logic [63:0]        lo, hi, ax, ay;
      logic [159:0]       k160, lhs_m, reach, rhs_m, lhs_z, rhs_z;
      if (!p.valid) begin
        expected_verdicts.push_back('{1'b0, REASON_INVALID, reject_count});
        return;
      end
      dt = p.elapsed_us;
      if (dt <= TICK_US) begin
        dt = TICK_US;
      end else if (dt > MAX_US) begin
        dt = MAX_US;
      end
      if (anchored && p.half_height != 0 && anchor_hh != 0) begin
        lo = (p.half_height < anchor_hh) ? p.half_height : anchor_hh;
        hi = (p.half_height > anchor_hh) ? p.half_height : anchor_hh;
        dx = p.centre_x;
        dx = dx - anchor_x;
        dy = p.centre_y;
        dy = dy - anchor_y;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        k160 = 160'(SCALE_K);
        lhs_m = (160'(ax) * 160'(ax) + 160'(ay) * 160'(ay)) * k160 * k160;
        reach = 160'(lo) * 160'(hh_limit) * 160'(dt);
        rhs_m = reach * reach;
        zdelta = $signed({48'd0, zoom_limit}) - 64'sd256;
        inner = $signed({32'd0, SCALE_K}) + zdelta * dt;
        lhs_z = 160'(hi) * k160;
        rhs_z = 160'(lo) * 160'(inner);
        if ((lhs_m > rhs_m || lhs_z > rhs_z) && reject_count < reject_limit) begin
          if (reject_count != 8'hff) reject_count = reject_count + 8'd1;
          expected_verdicts.push_back('{1'b0, REASON_HELD, reject_count});
          return;
        end
      end
      anchored = 1'b1;
      anchor_x = p.centre_x;
      anchor_y = p.centre_y;
      anchor_hh = p.half_height;
      reject_count = '0;
      expected_verdicts.push_back('{1'b1, REASON_OK, 8'd0});
    endfunction

    function void check_verdict(logic [7:0] data, logic [2:0] user);
      verdict_t e;
      if (expected_verdicts.size() == 0) begin
        $error("result beat with no sample pending: tdata %h tuser %h", data, user);
        errors++;
        return;
      end
      e = expected_verdicts.pop_front();
      if (user[0] !== e.taken) begin
        $error("accepted: expected %0d, got %0d", e.taken, user[0]);
        errors++;
      end
      if (user[2:1] !== e.reason) begin
        $error("reason: expected %0d, got %0d", e.reason, user[2:1]);
        errors++;
      end
      if (data !== e.streak) begin
        $error("reject_run: expected %0d, got %0d", e.streak, data);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = CFG_HH;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [127:0]          s_axis_tdata = '0;
  logic [0:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;
  logic [2:0]            m_axis_tuser;

  pose_verdict_board board;
  int                cycle_count = 0;
  int unsigned       rx_tick = 0;
  int unsigned       rx_period = 1;
  int unsigned       rx_duty = 1;

  view_continuity_guard dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) board.check_verdict(m_axis_tdata, m_axis_tuser);
      rx_tick++;
      if (rx_tick % 97 == 0) begin
        rx_period = $urandom_range(1, 8);
        rx_duty = $urandom_range(1, rx_period);
      end
      m_axis_tready <= (rx_tick % rx_period) < rx_duty;
    end
  end

  function automatic pose_t pose(logic valid, logic signed [31:0] cx, logic signed [31:0] cy,
                                 logic [30:0] hh, logic signed [31:0] dt);
    pose_t p;
    p = '{valid, cx, cy, hh, dt};
    return p;
  endfunction

  function automatic pose_t random_pose();
    pose_t              p;
    int unsigned        pick;
    logic signed [63:0] dtc, zallow, cx;
    logic [63:0]        r, nh, m, allow, span, delta, k, offset;
    p = '{1'b1, $urandom, $urandom, 31'($urandom), $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      p.valid = 1'b0;
      return p;
    end
    if (pick < 12) begin
      if (pick < 8) p.half_height = '0;
      return p;
    end
    case ($urandom_range(0, 9))
      0: begin
        p.elapsed_us = $urandom_range(0, 30000);
        if ($urandom_range(0, 1)) p.elapsed_us = -p.elapsed_us;
      end
      1: p.elapsed_us = $urandom_range(1000001, 32'h7fffffff);
      2: p.elapsed_us = TICK_US;
      3: p.elapsed_us = MAX_US;
      default: p.elapsed_us = $urandom_range(16000, 1000000);
    endcase
    dtc = p.elapsed_us;
    if (dtc <= TICK_US) begin
      dtc = TICK_US;
    end else if (dtc > MAX_US) begin
      dtc = MAX_US;
    end
    r = board.anchor_hh;
    if (!board.anchored || r == 0) begin
      p.half_height = 31'($urandom_range(1, 1 << 20));
      p.centre_x = $urandom_range(0, 1 << 24);
      p.centre_y = $urandom_range(0, 1 << 24);
      return p;
    end
    zallow = ($signed({48'd0, board.zoom_limit}) - 64'sd256) * dtc / 64'sd1000000;
    span = (zallow > 0) ? 64'(zallow) * 2 + 4 : 64'd4;
    delta = ($urandom_range(0, 2) == 0) ? 64'd0 : 64'($urandom_range(0, 32'(span)));
    nh = $urandom_range(0, 1) ? r * (256 + delta) / 256 : r * 256 / (256 + delta);
    if (nh == 0) nh = 1;
    if (nh > 64'h7fffffff) nh = 64'h7fffffff;
    p.half_height = nh[30:0];
    m = (nh < r) ? nh : r;
    allow = 64'(board.hh_limit) * 64'(dtc) / 1000000;
    k = ($urandom_range(0, 2) == 0) ? 64'd0 : 64'($urandom_range(0, 32'(allow * 2 + 4)));
    offset = m * k / 256;
    cx = board.anchor_x;
    cx = $urandom_range(0, 1) ? cx + $signed(offset) : cx - $signed(offset);
    p.centre_x = cx[31:0];
    p.centre_y = board.anchor_y + 32'($urandom_range(0, 32'(offset / 4)));
    return p;
  endfunction

  task automatic send_pose(input pose_t p);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= p.valid;
    s_axis_tdata <= {1'b0, p.elapsed_us, p.half_height, p.centre_y, p.centre_x};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    board.note_sample(p);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_limits(input logic [15:0] hh, input logic [15:0] zoom,
                                input logic [7:0] rej);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_HH;
    cfg_data_i <= hh;
    @(posedge clk_i);
    board.write_reg(CFG_HH, hh);
    cfg_idx_i <= CFG_ZOOM;
    cfg_data_i <= zoom;
    @(posedge clk_i);
    board.write_reg(CFG_ZOOM, zoom);
    cfg_idx_i <= CFG_REJ;
    cfg_data_i <= {8'd0, rej};
    @(posedge clk_i);
    board.write_reg(CFG_REJ, {8'd0, rej});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_phase(input int items);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < items) begin
      burst = $urandom_range(1, 10);
      for (int i = 0; i < burst && sent < items; i++) begin
        send_pose(random_pose());
        sent++;
      end
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  logic [15:0] phase_hh [8] = '{16'd1024, 16'd65535, 16'd1, 16'd0,
                                16'd256, 16'd4096, 16'd65535, 16'd0};
  logic [15:0] phase_zoom [8] = '{16'd512, 16'd65535, 16'd256, 16'd128,
                                  16'd300, 16'd1024, 16'd256, 16'd0};
  logic [7:0] phase_rej [8] = '{8'd3, 8'd255, 8'd0, 8'd2, 8'd8, 8'd1, 8'd255, 8'd0};

  initial begin
    board = new;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pose(pose(1'b0, -1, -1, 31'h7fffffff, -1));
    send_pose(pose(1'b1, 32'sh7fffffff, 32'sh80000000, 31'd0, 0));
    send_pose(pose(1'b1, 0, 0, 31'd4096, -5));
    send_pose(pose(1'b1, 0, 0, 31'd8192, 1000000));
    send_pose(pose(1'b1, 0, 0, 31'd16385, 32'sh7fffffff));
    send_pose(pose(1'b1, 32768, 0, 31'd8192, 1000000));
    send_pose(pose(1'b1, 32768 + 32769, 0, 31'd8192, 1000000));
    send_pose(pose(1'b0, 0, 0, 31'd0, 0));
    send_pose(pose(1'b1, 32'sh80000000, 32'sh7fffffff, 31'd8192, 16000));
    send_pose(pose(1'b1, 32'sh80000000, 32'sh80000000, 31'd8192, 0));
    send_pose(pose(1'b1, 32'sh80000000, 32'sh80000000, 31'd8192, 0));
    send_pose(pose(1'b1, 0, 0, 31'd0, 16000));
    drain();

    program_limits(16'd1024, 16'd512, 8'd255);
    send_pose(pose(1'b1, 0, 0, 31'd4096, 16000));
    for (int i = 0; i < 5; i++) send_pose(pose(1'b1, 1 << 20, 0, 31'd4096, 16000 + i));
    drain();
    program_limits(16'd1024, 16'd512, 8'd1);
    send_pose(pose(1'b1, 1 << 20, 0, 31'd4096, 16000));
    send_pose(pose(1'b1, 1 << 20, 1, 31'd4096, 16000));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) begin
        program_limits(16'($urandom_range(1, 65535)), 16'($urandom_range(256, 65535)),
                       8'($urandom_range(0, 6)));
      end else begin
        program_limits(phase_hh[ph], phase_zoom[ph], phase_rej[ph]);
      end
      random_phase(PHASE_ITEMS);
      drain();
    end

    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
